[hdl/epoch_seconds_to_calendar_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the epoch seconds to calendar block
// Clocked, reset-qualified property wrappers shared by the checker.
// ---------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// General form with an explicit clock and active-low reset.
`define ESC_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Short form using the block clock and reset names.
`define ESC_ASSERT(lbl, prop, msg) \
	`ESC_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

[hdl/esc_pkg.sv]
// ---------------------------------------------------------------------------
// Epoch seconds to calendar package
// Types, constants and the month length table shared by the block files.
// ---------------------------------------------------------------------------
package esc_pkg;

	localparam int unsigned IN_TDATA_W   = 32;
	localparam int unsigned OUT_TDATA_W  = 48;

	localparam int unsigned YEAR_W       = 12;
	localparam int unsigned MONTH_W      = 4;
	localparam int unsigned DAY_W        = 5;
	localparam int unsigned HOUR_W       = 5;
	localparam int unsigned MINUTE_W     = 6;
	localparam int unsigned SECOND_W     = 6;
	localparam int unsigned WEEKDAY_W    = 3;

	localparam int unsigned DAYS_W       = 16;
	localparam int unsigned REM_W        = 17;
	localparam int unsigned CNT_W        = 6;

	localparam logic [REM_W-1:0]  SECS_PER_DAY  = 17'd86400;
	localparam logic [REM_W-1:0]  SECS_PER_HOUR = 17'd3600;
	localparam logic [REM_W-1:0]  SECS_PER_MIN  = 17'd60;
	localparam logic [REM_W-1:0]  DAYS_PER_WEEK = 17'd7;

	localparam logic [CNT_W-1:0]  STEPS_DAY     = 6'd32;
	localparam logic [CNT_W-1:0]  STEPS_HOUR    = 6'd17;
	localparam logic [CNT_W-1:0]  STEPS_MIN     = 6'd12;
	localparam logic [CNT_W-1:0]  STEPS_WDAY    = 6'd17;

	localparam logic [DAYS_W:0]   EPOCH_WEEKDAY = 17'd4;

	localparam logic [YEAR_W-1:0] FIRST_YEAR    = 12'd1970;
	localparam logic [1:0]        FIRST_MOD4    = 2'd2;
	localparam logic [6:0]        FIRST_MOD100  = 7'd70;
	localparam logic [8:0]        FIRST_MOD400  = 9'd370;
	localparam logic [6:0]        LAST_MOD100   = 7'd99;
	localparam logic [8:0]        LAST_MOD400   = 9'd399;

	localparam logic [8:0]        DAYS_COMMON   = 9'd365;
	localparam logic [8:0]        DAYS_LEAP     = 9'd366;

	localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd0;
	localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_DAY,
		ST_DIV_HOUR,
		ST_DIV_MIN,
		ST_DIV_WDAY,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} esc_state_t;

	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd0:    len = 5'd31;
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

[hdl/epoch_seconds_to_calendar.sv]
// A conversion runs four long divisions (days, hours, minutes, weekday), then steps whole
// years and then months off the day count before loading the output register.
// The block takes no new input until a conversion is through; one long-division step,
// shared by all four divisions, and subtract-and-compare logic for years and months do the work.
// A new input is taken while the previous result waits in the output register.
// Reset clears the sequencer and the output valid.
// ---------------------------------------------------------------------------
// Epoch seconds to calendar converter
// Splits a 32-bit seconds count since 1970 into date, time of day and weekday.
// ---------------------------------------------------------------------------
module epoch_seconds_to_calendar
	import esc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] epoch_seconds
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [11:0] year, [15:12] month_index, [20:16] day_of_month, [25:21] hour,
	// [31:26] minute, [37:32] second, [40:38] weekday, [47:41] zero
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	esc_state_t             state_q, state_d;
	logic [CNT_W-1:0]       cnt_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic [31:0]            num_q;
	logic [REM_W-1:0]       rem_q;
	logic [DAYS_W-1:0]      days_q;
	logic [DAYS_W-1:0]      left_q;
	logic [HOUR_W-1:0]      hour_q;
	logic [MINUTE_W-1:0]    minute_q;
	logic [SECOND_W-1:0]    second_q;
	logic [WEEKDAY_W-1:0]   weekday_q;
	logic [YEAR_W-1:0]      year_q;
	logic [MONTH_W-1:0]     month_q;
	logic [1:0]             mod4_q;
	logic [6:0]             mod100_q;
	logic [8:0]             mod400_q;

	logic [REM_W-1:0]       divisor;
	logic [REM_W:0]         div_shift;
	logic                   q_bit;
	logic [REM_W-1:0]       rem_nxt;
	logic                   div_last;
	logic                   leap;
	logic [8:0]             year_len;
	logic                   year_step;
	logic [DAY_W-1:0]       month_len;
	logic                   month_step;
	logic                   s_accept;
	logic                   out_load;

	assign s_accept   = s_tvalid && s_tready;
	assign div_last   = (cnt_q == CNT_W'(1));

	always_comb begin
		unique case (state_q)
			ST_DIV_HOUR: divisor = SECS_PER_HOUR;
			ST_DIV_MIN:  divisor = SECS_PER_MIN;
			ST_DIV_WDAY: divisor = DAYS_PER_WEEK;
			default:     divisor = SECS_PER_DAY;
		endcase
	end

	assign div_shift = {rem_q, num_q[31]};
	assign q_bit     = (div_shift >= {1'b0, divisor});
	assign rem_nxt   = q_bit ? REM_W'(div_shift - {1'b0, divisor}) : div_shift[REM_W-1:0];

	assign leap       = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
	assign year_len   = leap ? DAYS_LEAP : DAYS_COMMON;
	assign year_step  = ({7'd0, left_q} >= {7'd0, 7'd0, year_len});
	assign month_len  = month_length(month_q, leap);
	assign month_step = (month_q != MONTH_DEC) && (left_q >= {11'd0, month_len});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_DIV_DAY;
				end
			end
			ST_DIV_DAY: begin
				if (div_last) begin
					state_d = ST_DIV_HOUR;
				end
			end
			ST_DIV_HOUR: begin
				if (div_last) begin
					state_d = ST_DIV_MIN;
				end
			end
			ST_DIV_MIN: begin
				if (div_last) begin
					state_d = ST_DIV_WDAY;
				end
			end
			ST_DIV_WDAY: begin
				if (div_last) begin
					state_d = ST_YEAR;
				end
			end
			ST_YEAR: begin
				if (!year_step) begin
					state_d = ST_MONTH;
				end
			end
			ST_MONTH: begin
				if (!month_step) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				cnt_q <= STEPS_DAY;
			end else if (cnt_q != '0) begin
				if (div_last) begin
					unique case (state_q)
						ST_DIV_DAY:  cnt_q <= STEPS_HOUR;
						ST_DIV_HOUR: cnt_q <= STEPS_MIN;
						ST_DIV_MIN:  cnt_q <= STEPS_WDAY;
						default:     cnt_q <= '0;
					endcase
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					num_q <= s_tdata;
					rem_q <= '0;
				end
			end
			ST_DIV_DAY, ST_DIV_HOUR, ST_DIV_MIN, ST_DIV_WDAY: begin
				if (!div_last) begin
					num_q <= {num_q[30:0], q_bit};
					rem_q <= rem_nxt;
				end else begin
					rem_q <= '0;
					unique case (state_q)
						ST_DIV_DAY: begin
							days_q <= {num_q[DAYS_W-2:0], q_bit};
							num_q  <= {rem_nxt, 15'd0};
						end
						ST_DIV_HOUR: begin
							hour_q <= {num_q[HOUR_W-2:0], q_bit};
							num_q  <= {rem_nxt[11:0], 20'd0};
						end
						ST_DIV_MIN: begin
							minute_q <= {num_q[MINUTE_W-2:0], q_bit};
							second_q <= rem_nxt[SECOND_W-1:0];
							num_q    <= {({1'b0, days_q} + EPOCH_WEEKDAY), 15'd0};
						end
						default: begin
							weekday_q <= rem_nxt[WEEKDAY_W-1:0];
							left_q    <= days_q;
							year_q    <= FIRST_YEAR;
							mod4_q    <= FIRST_MOD4;
							mod100_q  <= FIRST_MOD100;
							mod400_q  <= FIRST_MOD400;
						end
					endcase
				end
			end
			ST_YEAR: begin
				if (year_step) begin
					left_q   <= left_q - {7'd0, year_len};
					year_q   <= year_q + YEAR_W'(1);
					mod4_q   <= mod4_q + 2'd1;
					mod100_q <= (mod100_q == LAST_MOD100) ? 7'd0 : mod100_q + 7'd1;
					mod400_q <= (mod400_q == LAST_MOD400) ? 9'd0 : mod400_q + 9'd1;
				end else begin
					month_q <= MONTH_JAN;
				end
			end
			ST_MONTH: begin
				if (month_step) begin
					left_q  <= left_q - {11'd0, month_len};
					month_q <= month_q + MONTH_W'(1);
				end
			end
			ST_DONE: begin
				if (out_load) begin
					m_tdata_q <= {7'd0, weekday_q, second_q, minute_q, hour_q,
						DAY_W'(left_q[DAY_W-1:0] + DAY_W'(1)), month_q, year_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[hdl/esc_checker.sv]
// ---------------------------------------------------------------------------
// Epoch seconds to calendar port checker
// Watches the stream ports of the converter and checks result ranges.
// ---------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_assert.svh"

module esc_checker
	import esc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] epoch_seconds
	input logic                   m_tvalid,
	input logic                   m_tready,
	// [11:0] year, [15:12] month_index, [20:16] day_of_month, [25:21] hour,
	// [31:26] minute, [37:32] second, [40:38] weekday
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic date_ok;
	logic time_ok;

	assign date_ok = (m_tdata[15:12] <= 4'd11) && (m_tdata[20:16] != 5'd0) &&
		(m_tdata[40:38] <= 3'd6) && (m_tdata[11:0] >= 12'd1970) &&
		(m_tdata[11:0] <= 12'd2106);
	assign time_ok = (m_tdata[25:21] <= 5'd23) && (m_tdata[31:26] <= 6'd59) &&
		(m_tdata[37:32] <= 6'd59);

	// A stalled result transaction keeps its data.
	`ESC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

	// A waiting input transaction keeps its data.
	`ESC_ASSERT(a_in_hold, s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata), "input changed while waiting")

	// Once a conversion starts the block takes nothing else.
	`ESC_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "input taken during conversion")

	// Date fields stay within the calendar.
	`ESC_ASSERT(a_date_range, m_tvalid |-> date_ok, "date field out of range")

	// Time of day fields stay within the clock face.
	`ESC_ASSERT(a_time_range, m_tvalid |-> time_ok, "time field out of range")

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);

[tb/sv/tb_epoch_seconds_to_calendar.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the epoch seconds to calendar converter
// Streams second counts into the block and checks every calendar breakdown
// against a behavioural conversion kept in the testbench. Boundary dates come
// first, then random counts biased towards midnight and month ends, with
// random gaps on both streams, a long output stall and a full drain pause.
// ---------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;
	import esc_pkg::*;

	localparam int unsigned HALF_PERIOD  = 10;
	localparam int unsigned RESET_CYCLES = 9;
	localparam int unsigned LONG_HOLD    = 600;
	localparam int unsigned HOLD_AT      = 80;
	localparam int unsigned SETTLE       = 300;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned RANDOM_BULK  = 365;
	localparam int unsigned RANDOM_TAIL  = 60;
	localparam int unsigned LAST_DAY     = 49710;
	localparam int unsigned DAY_SECS     = 86400;

	localparam int unsigned MONTH_LENGTHS [12] = '{31, 28, 31, 30, 31, 30,
		31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic [YEAR_W-1:0]    year;
		logic [MONTH_W-1:0]   month;
		logic [DAY_W-1:0]     mday;
		logic [HOUR_W-1:0]    hour;
		logic [MINUTE_W-1:0]  minute;
		logic [SECOND_W-1:0]  second;
		logic [WEEKDAY_W-1:0] wday;
	} calendar_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [31:0] epoch_seconds
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [11:0] year, [15:12] month_index, [20:16] day_of_month, [25:21] hour,
	// [31:26] minute, [37:32] second, [40:38] weekday, [47:41] zero
	logic [OUT_TDATA_W-1:0] m_tdata;

	logic [IN_TDATA_W-1:0] epochs_to_send [$];
	calendar_t             dates_due [$];

	int unsigned n_sent         = 0;
	int unsigned n_checked      = 0;
	int unsigned n_errors       = 0;
	int unsigned gap_left       = 0;
	int unsigned stall_left     = 0;
	int unsigned hold_left      = 0;
	int unsigned quiet_cycles   = 0;
	bit          long_hold_done = 1'b0;
	bit          calm           = 1'b0;
	bit          next_ready;
	calendar_t   want;
	calendar_t   got;

	epoch_seconds_to_calendar dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic bit is_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_span(input int unsigned m, input int unsigned y);
		if (m == 1 && is_leap(y)) begin
			return 29;
		end
		return MONTH_LENGTHS[m];
	endfunction

	function automatic calendar_t calendar_of(input logic [IN_TDATA_W-1:0] secs);
		int unsigned days;
		int unsigned tod;
		int unsigned left;
		int unsigned y;
		int unsigned m;
		int unsigned span;
		calendar_t   c;
		days     = secs / DAY_SECS;
		tod      = secs % DAY_SECS;
		c.hour   = HOUR_W'(tod / 3600);
		c.minute = MINUTE_W'((tod % 3600) / 60);
		c.second = SECOND_W'(tod % 60);
		c.wday   = WEEKDAY_W'((days + 4) % 7);
		left     = days;
		y        = 1970;
		span     = is_leap(y) ? 366 : 365;
		while (left >= span) begin
			left -= span;
			y++;
			span = is_leap(y) ? 366 : 365;
		end
		m = 0;
		while (m < 11 && left >= month_span(m, y)) begin
			left -= month_span(m, y);
			m++;
		end
		c.year  = YEAR_W'(y);
		c.month = MONTH_W'(m);
		c.mday  = DAY_W'(left + 1);
		return c;
	endfunction

	// Half of the counts are uniform; the rest sit on midnight or straddle the
	// first of a month, so that month and year carries are hit often.
	function automatic logic [IN_TDATA_W-1:0] random_epoch();
		int unsigned d;
		case ($urandom_range(0, 3))
			0, 1: begin
				return $urandom();
			end
			2: begin
				d = $urandom_range(0, LAST_DAY - 1);
				return d * DAY_SECS + ($urandom_range(0, 1) ? DAY_SECS - 1 : $urandom_range(0, 3));
			end
			default: begin
				d = $urandom_range(1, LAST_DAY);
				while (calendar_of(d * DAY_SECS).mday != 1) begin
					d = $urandom_range(1, LAST_DAY);
				end
				return d * DAY_SECS - $urandom_range(0, 1);
			end
		endcase
	endfunction

	task automatic wait_until_drained();
		do begin
			@(posedge clk);
		end while (epochs_to_send.size() != 0 || s_tvalid || dates_due.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				dates_due.push_back(calendar_of(s_tdata));
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (epochs_to_send.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!calm && ((n_sent / 32) % 4 != 3) && $urandom_range(0, 3) == 0) begin
					gap_left = $urandom_range(0, 6);
					s_tvalid <= 1'b0;
				end else begin
					s_tdata  <= epochs_to_send.pop_front();
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = calendar_t'({m_tdata[11:0], m_tdata[15:12], m_tdata[20:16],
					m_tdata[25:21], m_tdata[31:26], m_tdata[37:32], m_tdata[40:38]});
				if (dates_due.size() == 0) begin
					n_errors++;
					$display("%0t: result %h arrived with no conversion outstanding", $time,
						m_tdata);
				end else begin
					want = dates_due.pop_front();
					if (got.year != want.year) begin
						n_errors++;
						$display("%0t: year expected %0d actual %0d", $time, want.year, got.year);
					end
					if (got.month != want.month) begin
						n_errors++;
						$display("%0t: month_index expected %0d actual %0d", $time, want.month,
							got.month);
					end
					if (got.mday != want.mday) begin
						n_errors++;
						$display("%0t: day_of_month expected %0d actual %0d", $time, want.mday,
							got.mday);
					end
					if (got.hour != want.hour) begin
						n_errors++;
						$display("%0t: hour expected %0d actual %0d", $time, want.hour, got.hour);
					end
					if (got.minute != want.minute) begin
						n_errors++;
						$display("%0t: minute expected %0d actual %0d", $time, want.minute,
							got.minute);
					end
					if (got.second != want.second) begin
						n_errors++;
						$display("%0t: second expected %0d actual %0d", $time, want.second,
							got.second);
					end
					if (got.wday != want.wday) begin
						n_errors++;
						$display("%0t: weekday expected %0d actual %0d", $time, want.wday,
							got.wday);
					end
					if (m_tdata[47:41] != '0) begin
						n_errors++;
						$display("%0t: padding expected 0 actual %h", $time, m_tdata[47:41]);
					end
				end
				n_checked++;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (!long_hold_done && n_checked >= HOLD_AT) begin
				// Hold the output long enough for the input side to back up.
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD - 1;
				next_ready     = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else if (!calm && ((n_checked / 32) % 4 != 1) && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 6);
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			m_tready <= next_ready;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d conversions outstanding",
					$time, quiet_cycles, dates_due.size());
				$display("tb_epoch_seconds_to_calendar: FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Midnight and leap-day edges, century rules and the 32-bit limit.
		epochs_to_send = '{32'd0, 32'd1, 32'd60, 32'd3600, 32'd86399, 32'd86400,
			32'd68169599, 32'd68169600, 32'd68256000, 32'd94694399, 32'd94694400,
			32'd946684799, 32'd951782400, 32'd951868800, 32'd978307199, 32'd978307200,
			32'd2147483647, 32'd2147483648, 32'd4102444800, 32'd4107456000,
			32'd4107542400, 32'd4294944000, 32'd4294967295, 32'h55555555, 32'hAAAAAAAA};
		wait_until_drained();

		repeat (RANDOM_BULK) epochs_to_send.push_back(random_epoch());
		wait_until_drained();

		calm = 1'b1;
		repeat (RANDOM_TAIL) epochs_to_send.push_back(random_epoch());
		wait_until_drained();
		repeat (SETTLE) @(posedge clk);

		if (dates_due.size() != 0) begin
			n_errors++;
			$display("%0t: %0d conversions never returned", $time, dates_due.size());
		end
		$display("Converted %0d second counts, %0d results checked, %0d mismatches.", n_sent,
			n_checked, n_errors);
		$display("Covered leap days, century years, the 2106 limit, gaps and a long stall.");
		if (n_errors == 0) begin
			$display("tb_epoch_seconds_to_calendar: PASS");
		end else begin
			$display("tb_epoch_seconds_to_calendar: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/esc_pkg.sv
hdl/epoch_seconds_to_calendar.sv
hdl/esc_checker.sv
tb/sv/tb_epoch_seconds_to_calendar.sv
